FILE: hdl/dense_dijkstra_shortest_path_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the shortest-path block.
// Each macro expects a clock named clk and an active-low reset named rst_n.
// ---------------------------------------------------------------------------
`ifndef DENSE_DIJKSTRA_SHORTEST_PATH_DEFINES_SVH
`define DENSE_DIJKSTRA_SHORTEST_PATH_DEFINES_SVH

// Same-cycle implication.
`define DDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dds_pkg.sv
// ---------------------------------------------------------------------------
// dds_pkg
// Shared types and constants of the dense shortest-path block.
// ---------------------------------------------------------------------------
`default_nettype none

package dds_pkg;

  // Field widths.
  localparam int NODE_W   = 6;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 22;
  localparam int NCFG_W   = 7;
  localparam int CFG_W    = 22;
  localparam int CFGIDX_W = 1;

  // Built maximum node count default.
  localparam int MAX_NODES_DEF = 16;

  // Distance saturation value and register reset values.
  localparam logic [DIST_W-1:0] DIST_MAX        = 22'h3FFFFF;
  localparam logic [DIST_W-1:0] UNREACHED_RESET = 22'd99999;
  localparam logic [NCFG_W-1:0] NODE_CNT_RESET  = 7'd16;

  // Configuration register indexes.
  localparam logic [CFGIDX_W-1:0] REG_NODE_COUNT = 1'b0;
  localparam logic [CFGIDX_W-1:0] REG_UNREACHED  = 1'b1;

  // Operation codes of an input item.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_RELAX,
    ST_OUT
  } state_t;

  // Mode of the shared compare unit.
  typedef enum logic {
    ALU_SCAN,
    ALU_RELAX
  } alu_mode_t;

  // Verdict of the shared compare unit.
  typedef struct packed {
    logic              take;
    logic [DIST_W-1:0] value;
  } alu_res_t;

endpackage

`default_nettype wire

FILE: hdl/dds_alu.sv
// ---------------------------------------------------------------------------
// dds_alu
// Shared saturating adder and comparator used for both the minimum search
// and the edge relaxation.
// ---------------------------------------------------------------------------
`default_nettype none

module dds_alu (
  input  var dds_pkg::alu_mode_t               mode,
  input  var logic [dds_pkg::DIST_W-1:0]       cur_dist,
  input  var logic [dds_pkg::DIST_W-1:0]       ref_dist,
  input  var logic [dds_pkg::WEIGHT_W-1:0]     cost,
  input  var logic                             settled,
  output dds_pkg::alu_res_t                    res
);
  import dds_pkg::*;

  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] sat;
  logic [DIST_W-1:0] lhs;
  logic [DIST_W-1:0] rhs;

  // Candidate path length through the settled node, saturated.
  assign sum = {1'b0, ref_dist} + (DIST_W+1)'(cost);
  assign sat = (sum > (DIST_W+1)'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];

  // Scan compares a node's distance against the running minimum; relax
  // compares the candidate against the node's distance.
  always_comb begin
    unique case (mode)
      ALU_SCAN: begin
        lhs = cur_dist;
        rhs = ref_dist;
      end
      ALU_RELAX: begin
        lhs = sat;
        rhs = cur_dist;
      end
      default: begin
        lhs = cur_dist;
        rhs = ref_dist;
      end
    endcase
  end

  assign res.take  = !settled && (lhs < rhs);
  assign res.value = lhs;

endmodule

`default_nettype wire

FILE: hdl/dense_dijkstra_shortest_path.sv
// Load item: taken while idle with no result; busy stays low.
// Run item over n nodes: one shared compare unit steps one node per cycle through an init pass,
// up to n - 1 search and relax pass pairs and an output pass. Results leave one per cycle, n in
// a row, in the output pass; the receiver cannot stall.
// Synchronous active-low reset sets node_count 16, unreached_limit 99999 and the idle state.
// ---------------------------------------------------------------------------
// dense_dijkstra_shortest_path
// Single-source shortest paths over a dense cost matrix held in memory.
// ---------------------------------------------------------------------------
`default_nettype none

`include "dense_dijkstra_shortest_path_defines.svh"

module dense_dijkstra_shortest_path #(
  parameter int MAX_NODES = dds_pkg::MAX_NODES_DEF
) (
  input  var logic                              clk,
  input  var logic                              rst_n,
  // Command channel.
  input  var logic                              start,
  output logic                                  busy,
  input  var logic                              in_operation,
  input  var logic [dds_pkg::NODE_W-1:0]        in_from_node,
  input  var logic [dds_pkg::NODE_W-1:0]        in_to_node,
  input  var logic [dds_pkg::WEIGHT_W-1:0]      in_edge_weight,
  input  var logic [dds_pkg::NODE_W-1:0]        in_source_node,
  // Result channel.
  output logic                                  out_valid,
  output logic [dds_pkg::NODE_W-1:0]            out_node,
  output logic [dds_pkg::DIST_W-1:0]            out_path_distance,
  output logic                                  out_last,
  // Configuration port.
  input  var logic                              cfg_we,
  input  var logic [dds_pkg::CFGIDX_W-1:0]      cfg_index,
  input  var logic [dds_pkg::CFG_W-1:0]         cfg_data
);
  import dds_pkg::*;

  localparam int CDEPTH = MAX_NODES * MAX_NODES;
  localparam int AW     = $clog2(CDEPTH);
  localparam int IW     = $clog2(MAX_NODES);
  localparam int CW     = $clog2(MAX_NODES + 1);

  // Control state.
  state_t                state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  pv_r, pv_nxt;
  logic [IW-1:0]         pidx_r, pidx_nxt;
  logic [CW-1:0]         n_r, n_nxt;
  logic [IW-1:0]         src_r, src_nxt;
  logic [MAX_NODES-1:0]  settled_r, settled_nxt;
  logic [DIST_W-1:0]     least_r, least_nxt;
  logic [IW-1:0]         pick_r, pick_nxt;
  logic                  have_r, have_nxt;
  logic [CW-1:0]         round_r, round_nxt;
  logic [NCFG_W-1:0]     node_count_r;
  logic [DIST_W-1:0]     unreached_r;

  // Result registers.
  logic                  out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]     out_node_r, out_node_nxt;
  logic [DIST_W-1:0]     out_dist_r, out_dist_nxt;
  logic                  out_last_r, out_last_nxt;

  // Memories and their ports.
  logic [WEIGHT_W-1:0]   cost_mem [CDEPTH];
  logic [DIST_W-1:0]     dist_mem [MAX_NODES];
  logic [WEIGHT_W-1:0]   cost_rd_r;
  logic [DIST_W-1:0]     dist_rd_r;
  logic                  cost_we;
  logic [AW-1:0]         cost_waddr;
  logic [AW-1:0]         cost_raddr;
  logic [IW-1:0]         cost_rrow;
  logic                  dist_we;
  logic [DIST_W-1:0]     dist_wdata;

  logic [NCFG_W-1:0]     n_eff;
  logic                  load_ok;
  logic                  phase_done;
  alu_mode_t             alu_mode;
  alu_res_t              alu_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_CNT_RESET;
      unreached_r  <= UNREACHED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE_COUNT: node_count_r <= cfg_data[NCFG_W-1:0];
        REG_UNREACHED:  unreached_r  <= cfg_data[DIST_W-1:0];
        default:        ;
      endcase
    end
  end

  // Nodes in use, clamped to at least one and at most the built size.
  always_comb begin
    priority if (node_count_r == '0) begin
      n_eff = NCFG_W'(1);
    end else if (node_count_r > NCFG_W'(MAX_NODES)) begin
      n_eff = NCFG_W'(MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
  end

  assign load_ok = ({1'b0, in_from_node} < NCFG_W'(MAX_NODES)) &&
                   ({1'b0, in_to_node} < NCFG_W'(MAX_NODES));

  // Cost matrix addressing: row times the built size plus column.
  assign cost_waddr = AW'(AW'(in_from_node[IW-1:0]) * AW'(MAX_NODES)) +
                      AW'(in_to_node[IW-1:0]);
  assign cost_rrow  = (state_r == ST_INIT) ? src_r : pick_r;
  assign cost_raddr = AW'(AW'(cost_rrow) * AW'(MAX_NODES)) + AW'(cnt_r[IW-1:0]);

  // Cost matrix memory.
  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[cost_waddr] <= in_edge_weight;
    end
    cost_rd_r <= cost_mem[cost_raddr];
  end

  // Distance memory, read at the issue index and written behind it.
  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[pidx_r] <= dist_wdata;
    end
    dist_rd_r <= dist_mem[cnt_r[IW-1:0]];
  end

  // Shared compare unit.
  assign alu_mode = (state_r == ST_RELAX) ? ALU_RELAX : ALU_SCAN;

  dds_alu u_alu (
    .mode     (alu_mode),
    .cur_dist (dist_rd_r),
    .ref_dist (least_r),
    .cost     (cost_rd_r),
    .settled  (settled_r[pidx_r]),
    .res      (alu_res)
  );

  assign phase_done = (cnt_r == n_r) && !pv_r;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      pidx_r      <= '0;
      n_r         <= '0;
      src_r       <= '0;
      settled_r   <= '0;
      least_r     <= '0;
      pick_r      <= '0;
      have_r      <= 1'b0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pv_r        <= pv_nxt;
      pidx_r      <= pidx_nxt;
      n_r         <= n_nxt;
      src_r       <= src_nxt;
      settled_r   <= settled_nxt;
      least_r     <= least_nxt;
      pick_r      <= pick_nxt;
      have_r      <= have_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_node_r <= out_node_nxt;
    out_dist_r <= out_dist_nxt;
    out_last_r <= out_last_nxt;
  end

  // Next state and datapath control.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    n_nxt         = n_r;
    src_nxt       = src_r;
    settled_nxt   = settled_r;
    least_nxt     = least_r;
    pick_nxt      = pick_r;
    have_nxt      = have_r;
    round_nxt     = round_r;
    out_valid_nxt = 1'b0;
    out_node_nxt  = out_node_r;
    out_dist_nxt  = out_dist_r;
    out_last_nxt  = out_last_r;
    cost_we       = 1'b0;
    dist_we       = 1'b0;
    dist_wdata    = alu_res.value;

    // Every pass issues one node index per cycle; the read comes back in the
    // next cycle tagged with that index.
    if (state_r != ST_IDLE && cnt_r < n_r) begin
      pv_nxt   = 1'b1;
      pidx_nxt = cnt_r[IW-1:0];
      cnt_nxt  = cnt_r + CW'(1);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_operation == OP_LOAD) begin
            cost_we = load_ok;
          end else if ({1'b0, in_source_node} < n_eff) begin
            n_nxt       = CW'(n_eff);
            src_nxt     = in_source_node[IW-1:0];
            settled_nxt = '0;
            settled_nxt[in_source_node[IW-1:0]] = 1'b1;
            cnt_nxt     = '0;
            round_nxt   = '0;
            state_nxt   = ST_INIT;
          end
        end
      end

      // Copy the source's cost row into the distances, source at zero.
      ST_INIT: begin
        if (pv_r) begin
          dist_we    = 1'b1;
          dist_wdata = (pidx_r == src_r) ? '0 : DIST_W'(cost_rd_r);
        end
        if (phase_done) begin
          cnt_nxt   = '0;
          least_nxt = unreached_r;
          have_nxt  = 1'b0;
          state_nxt = (n_r == CW'(1)) ? ST_OUT : ST_SCAN;
        end
      end

      // Search for the nearest unsettled node below the limit.
      ST_SCAN: begin
        if (pv_r && alu_res.take) begin
          least_nxt = alu_res.value;
          pick_nxt  = pidx_r;
          have_nxt  = 1'b1;
        end
        if (phase_done) begin
          cnt_nxt = '0;
          if (!have_r) begin
            state_nxt = ST_OUT;
          end else begin
            settled_nxt[pick_r] = 1'b1;
            round_nxt = round_r + CW'(1);
            state_nxt = ST_RELAX;
          end
        end
      end

      // Relax every unsettled neighbor through the picked node.
      ST_RELAX: begin
        if (pv_r && alu_res.take) begin
          dist_we = 1'b1;
        end
        if (phase_done) begin
          cnt_nxt   = '0;
          least_nxt = unreached_r;
          have_nxt  = 1'b0;
          state_nxt = ((round_r + CW'(1)) < n_r) ? ST_SCAN : ST_OUT;
        end
      end

      // Stream out the final distances in node order.
      ST_OUT: begin
        if (pv_r) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = NODE_W'(pidx_r);
          out_dist_nxt  = dist_rd_r;
          out_last_nxt  = (pidx_r == IW'(n_r - CW'(1)));
        end
        if (phase_done) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Ports.
  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_node          = out_node_r;
  assign out_path_distance = out_dist_r;
  assign out_last          = out_last_r;

  // Checks.
  `DDS_ASSERT_IMP(a_out_in_run, out_valid_r, state_r != ST_IDLE, "result outside a run")
  `DDS_ASSERT_NXT(a_last_ends, out_valid_r && out_last_r, !out_valid_r, "result after last")
  `DDS_ASSERT_IMP(a_tag_bound, pv_r, pidx_r < n_r, "node tag beyond nodes in use")
  `DDS_ASSERT_NXT(a_load_idle, start && !busy && in_operation == OP_LOAD, state_r == ST_IDLE, "load left idle")

endmodule

`default_nettype wire

FILE: tb/sv/dds_path_checker.sv
// ---------------------------------------------------------------------------
// dds_path_checker
// Watches the command, result and configuration ports of the shortest-path
// block. It keeps its own cost matrix and register copies, solves every
// accepted run item and compares each node distance that comes out against
// the oldest one still owed.
// ---------------------------------------------------------------------------
module dds_path_checker #(
  parameter int MAX_NODES = dds_pkg::MAX_NODES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           in_operation,
  input  logic [dds_pkg::NODE_W-1:0]     in_from_node,
  input  logic [dds_pkg::NODE_W-1:0]     in_to_node,
  input  logic [dds_pkg::WEIGHT_W-1:0]   in_edge_weight,
  input  logic [dds_pkg::NODE_W-1:0]     in_source_node,
  input  logic                           out_valid,
  input  logic [dds_pkg::NODE_W-1:0]     out_node,
  input  logic [dds_pkg::DIST_W-1:0]     out_path_distance,
  input  logic                           out_last,
  input  logic                           cfg_we,
  input  logic [dds_pkg::CFGIDX_W-1:0]   cfg_index,
  input  logic [dds_pkg::CFG_W-1:0]      cfg_data,
  output int                             fail_count,
  output int                             pending_count,
  output int                             runs_solved,
  output int                             results_checked
);
  import dds_pkg::*;

  // One node distance owed by the block.
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [DIST_W-1:0] distance;
    logic              last;
  } node_dist_t;

  node_dist_t          owed_dist_q[$];
  logic [WEIGHT_W-1:0] weight_mem [MAX_NODES][MAX_NODES];
  logic [NCFG_W-1:0]   node_count_q;
  logic [DIST_W-1:0]   limit_q;

  initial begin
    fail_count      = 0;
    pending_count   = 0;
    runs_solved     = 0;
    results_checked = 0;
    node_count_q    = NODE_CNT_RESET;
    limit_q         = UNREACHED_RESET;
    for (int r = 0; r < MAX_NODES; r++)
      for (int c = 0; c < MAX_NODES; c++)
        weight_mem[r][c] = '0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Node count in effect: zero acts as one, anything above the built size
  // acts as the built size.
  function automatic int nodes_in_effect();
    int n;
    n = int'(node_count_q);
    if (n > MAX_NODES)
      n = MAX_NODES;
    if (n == 0)
      n = 1;
    return n;
  endfunction

  // Dense Dijkstra from one source; queues one distance per node in use.
  task automatic solve_from_source(input int src);
    logic [DIST_W-1:0] best [MAX_NODES];
    bit                fixed [MAX_NODES];
    logic [DIST_W-1:0] least;
    logic [DIST_W:0]   sum;
    node_dist_t        nd;
    bit                found;
    int                n;
    int                pick;
    n = nodes_in_effect();
    if (src >= n)
      return;
    for (int i = 0; i < n; i++) begin
      fixed[i] = 1'b0;
      best[i]  = DIST_W'(weight_mem[src][i]);
    end
    fixed[src] = 1'b1;
    best[src]  = '0;
    for (int round = 0; round + 1 < n; round++) begin
      least = limit_q;
      found = 1'b0;
      pick  = 0;
      // Strict compare keeps the lowest index among equal distances.
      for (int i = 0; i < n; i++) begin
        if (!fixed[i] && best[i] < least) begin
          least = best[i];
          pick  = i;
          found = 1'b1;
        end
      end
      // Nothing below the unreached limit: the remaining rounds are skipped.
      if (!found)
        break;
      fixed[pick] = 1'b1;
      for (int w = 0; w < n; w++) begin
        if (!fixed[w]) begin
          sum = {1'b0, best[pick]} + (DIST_W+1)'(weight_mem[pick][w]);
          if (sum > {1'b0, DIST_MAX})
            sum = {1'b0, DIST_MAX};
          if (sum[DIST_W-1:0] < best[w])
            best[w] = sum[DIST_W-1:0];
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      nd.node     = NODE_W'(i);
      nd.distance = best[i];
      nd.last     = (i == n - 1);
      owed_dist_q.push_back(nd);
    end
    runs_solved++;
  endtask

  always @(posedge clk) begin : watch
    node_dist_t due;
    if (!rst_n) begin
      node_count_q = NODE_CNT_RESET;
      limit_q      = UNREACHED_RESET;
    end else begin
      // Results first: they belong to items accepted earlier.
      if (out_valid) begin
        if (owed_dist_q.size() == 0) begin
          report_mismatch($sformatf("result for node %0d with nothing owed", out_node));
        end else begin
          due = owed_dist_q.pop_front();
          results_checked++;
          if (out_node !== due.node)
            report_mismatch($sformatf("node got %0d, want %0d", out_node, due.node));
          if (out_path_distance !== due.distance)
            report_mismatch($sformatf("distance of node %0d got %0d, want %0d",
                                      due.node, out_path_distance, due.distance));
          if (out_last !== due.last)
            report_mismatch($sformatf("last of node %0d got %0b, want %0b",
                                      due.node, out_last, due.last));
        end
      end
      // Register writes.
      if (cfg_we) begin
        case (cfg_index)
          REG_NODE_COUNT: node_count_q = cfg_data[NCFG_W-1:0];
          REG_UNREACHED:  limit_q      = cfg_data[DIST_W-1:0] & DIST_MAX;
          default: ;
        endcase
      end
      // Accepted items: loads outside the built matrix are dropped.
      if (start && !busy) begin
        if (in_operation == OP_LOAD) begin
          if (in_from_node < MAX_NODES && in_to_node < MAX_NODES)
            weight_mem[in_from_node][in_to_node] = in_edge_weight;
        end else begin
          solve_from_source(int'(in_source_node));
        end
      end
    end
    pending_count = owed_dist_q.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Drives load and run items and register writes into the shortest-path
// block in random bursts, and gives the verdict from the checker's failure and pending counts.
// ---------------------------------------------------------------------------
module tb_top;
  import dds_pkg::*;

  localparam int MAX_NODES  = MAX_NODES_DEF;
  localparam int ITEMS      = 210;
  localparam int MAX_GAP    = 24;
  // Longest run of the block plus margin.
  localparam int RUN_CYCLES = 2 * MAX_NODES * MAX_NODES + 5 * MAX_NODES + 16;
  localparam int LIMIT      = 4 * (RUN_CYCLES + MAX_GAP);

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_operation;
  logic [NODE_W-1:0]     in_from_node;
  logic [NODE_W-1:0]     in_to_node;
  logic [WEIGHT_W-1:0]   in_edge_weight;
  logic [NODE_W-1:0]     in_source_node;
  logic                  out_valid;
  logic [NODE_W-1:0]     out_node;
  logic [DIST_W-1:0]     out_path_distance;
  logic                  out_last;
  logic                  cfg_we;
  logic [CFGIDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  int fail_count;
  int pending_count;
  int runs_solved;
  int results_checked;

  // Stimulus bookkeeping.
  bit written [MAX_NODES][MAX_NODES];
  int live_nodes = int'(NODE_CNT_RESET);
  int burst_left = 0;
  int load_count = 0;
  int run_count  = 0;
  int reg_writes = 0;

  // Node counts of the random phases; extremes come early.
  int size_plan[12] = '{2, 16, 5, 1, 127, 4, 0, 64, 3, 17, 7, 10};
  // Small graph for the directed part: ties, zero and full-scale weights.
  int corner_w[9]   = '{65535, 65535, 5, 0, 7, 0, 3, 5, 65535};

  dense_dijkstra_shortest_path #(.MAX_NODES(MAX_NODES)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_from_node      (in_from_node),
    .in_to_node        (in_to_node),
    .in_edge_weight    (in_edge_weight),
    .in_source_node    (in_source_node),
    .out_valid         (out_valid),
    .out_node          (out_node),
    .out_path_distance (out_path_distance),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  dds_path_checker #(.MAX_NODES(MAX_NODES)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_from_node      (in_from_node),
    .in_to_node        (in_to_node),
    .in_edge_weight    (in_edge_weight),
    .in_source_node    (in_source_node),
    .out_valid         (out_valid),
    .out_node          (out_node),
    .out_path_distance (out_path_distance),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending_count     (pending_count),
    .runs_solved       (runs_solved),
    .results_checked   (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Ends the run when nothing is accepted, written or put out for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid || cfg_we)
        idle = 0;
      else
        idle++;
    end
    $display("Timeout after %0d idle cycles, %0d results still owed", LIMIT, pending_count);
    $display("Simulation FAILED");
    $finish;
  end

  // Mostly small weights so that paths through other nodes win.
  function automatic logic [WEIGHT_W-1:0] random_weight();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return WEIGHT_W'($urandom_range(1, 20));
      5, 6:    return WEIGHT_W'($urandom_range(0, 1000));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  // Presents one item; after acceptance either keeps start high for the
  // next item of the burst or drops it for a random gap.
  task automatic send_item(input logic op, input logic [NODE_W-1:0] from_n,
                           input logic [NODE_W-1:0] to_n,
                           input logic [WEIGHT_W-1:0] weight,
                           input logic [NODE_W-1:0] src);
    int gap;
    @(negedge clk);
    in_operation   <= op;
    in_from_node   <= from_n;
    in_to_node     <= to_n;
    in_edge_weight <= weight;
    in_source_node <= src;
    start          <= 1'b1;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    if (op == OP_LOAD) begin
      load_count++;
      if (from_n < MAX_NODES && to_n < MAX_NODES)
        written[from_n][to_n] = 1'b1;
    end else begin
      run_count++;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(1, MAX_GAP);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(0, 8);
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic load_weight(input int r, input int c, input logic [WEIGHT_W-1:0] w);
    send_item(OP_LOAD, NODE_W'(r), NODE_W'(c), w, NODE_W'($urandom));
  endtask

  task automatic run_from(input int src);
    send_item(OP_RUN, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_W'($urandom),
              NODE_W'(src));
  endtask

  // Holds items back until every owed distance has come out.
  task automatic drain();
    @(negedge clk) start <= 1'b0;
    while (pending_count != 0)
      @(negedge clk);
  endtask

  // Idle point for register writes: drain the owed distances, then wait
  // out a full run as well.
  task automatic quiesce();
    drain();
    repeat (RUN_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFGIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk) cfg_we <= 1'b0;
    reg_writes++;
  endtask

  // Node count lives in the low bits; the upper data bits are sometimes junk.
  task automatic set_node_count(input int value);
    logic [CFG_W-1:0] data;
    data = CFG_W'($urandom);
    if ($urandom_range(0, 1) == 0)
      data[CFG_W-1:NCFG_W] = '0;
    data[NCFG_W-1:0] = NCFG_W'(value);
    set_reg(REG_NODE_COUNT, data);
    live_nodes = (value > MAX_NODES) ? MAX_NODES : ((value == 0) ? 1 : value);
  endtask

  // A run reads the whole active square, so every entry of it gets a weight.
  task automatic fill_missing();
    for (int r = 0; r < live_nodes; r++)
      for (int c = 0; c < live_nodes; c++)
        if (!written[r][c])
          load_weight(r, c, random_weight());
  endtask

  initial begin : stimulus
    int               phase;
    int               len;
    int               random_items;
    int               roll;
    int               r;
    int               c;
    logic [DIST_W-1:0] lim;

    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = OP_LOAD;
    in_from_node   = '0;
    in_to_node     = '0;
    in_edge_weight = '0;
    in_source_node = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_NODE_COUNT;
    cfg_data       = '0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: a three-node graph with ties and full-scale weights, loads
    // outside the matrix, one beyond the node count, and sources out of range.
    set_node_count(3);
    for (int i = 0; i < 9; i++)
      load_weight(i / 3, i % 3, WEIGHT_W'(corner_w[i]));
    load_weight(63, 5, 16'hAAAA);
    load_weight(2, 63, 16'h5555);
    load_weight(16, 16, 16'hFFFF);
    load_weight(15, 15, 16'h0001);
    run_from(0);
    run_from(1);
    run_from(2);
    run_from(63);
    run_from(3);

    // Unreached limit at zero: no node ever qualifies.
    quiesce();
    set_reg(REG_UNREACHED, '0);
    run_from(0);
    // A small limit stops the search partway.
    quiesce();
    set_reg(REG_UNREACHED, CFG_W'(6));
    run_from(0);
    quiesce();
    set_reg(REG_UNREACHED, DIST_MAX);
    run_from(2);
    // Node count zero acts as a single node.
    quiesce();
    set_node_count(0);
    run_from(0);
    run_from(1);

    // Random phases: one node count and limit each, mostly well-formed
    // items over the active square with some noise.
    phase        = 0;
    random_items = 0;
    while (random_items < ITEMS) begin
      quiesce();
      set_node_count(size_plan[phase % 12]);
      case ($urandom_range(0, 4))
        0:       lim = DIST_W'($urandom_range(1, 40));
        1:       lim = DIST_MAX;
        2:       lim = DIST_W'($urandom_range(0, 200000));
        default: lim = UNREACHED_RESET;
      endcase
      set_reg(REG_UNREACHED, lim);
      fill_missing();
      len = $urandom_range(12, 28);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 24) == 0)
          drain();
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          run_from($urandom_range(0, live_nodes - 1));
          random_items++;
        end else if (roll < 85) begin
          load_weight($urandom_range(0, live_nodes - 1), $urandom_range(0, live_nodes - 1),
                      random_weight());
          random_items++;
        end else if (roll < 90 && live_nodes < MAX_NODES) begin
          // Entry beyond the node count: written and kept for later phases.
          r = $urandom_range(0, MAX_NODES - 1);
          c = $urandom_range(live_nodes, MAX_NODES - 1);
          if ($urandom_range(0, 1) == 0)
            load_weight(r, c, random_weight());
          else
            load_weight(c, r, random_weight());
          random_items++;
        end else if (roll < 95) begin
          // Load outside the built matrix: ignored.
          r = $urandom_range(0, 63);
          c = $urandom_range(0, 63);
          if ($urandom_range(0, 1) == 0)
            r = $urandom_range(MAX_NODES, 63);
          else
            c = $urandom_range(MAX_NODES, 63);
          load_weight(r, c, WEIGHT_W'($urandom));
        end else begin
          // Source at or above the node count: ignored.
          run_from($urandom_range(live_nodes, 63));
        end
      end
      phase++;
    end

    drain();
    repeat (RUN_CYCLES) @(negedge clk);
    $display("Sent %0d loads and %0d runs over %0d register writes in %0d random phases.",
             load_count, run_count, reg_writes, phase);
    $display("Checked %0d node distances from %0d runs that gave results.",
             results_checked, runs_solved);
    if (fail_count == 0 && pending_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
